[src/nbps_pkg.sv]
`default_nettype none

package nbps_pkg;

   // Table geometry and field widths
   localparam int TABLE_DEPTH = 64;
   localparam int POS_W       = 20;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SUM_W       = IDX_W + 2;
   localparam int ENTRY_W     = 6;
   localparam int BAR_W       = 6;
   localparam int BW_W        = 16;
   localparam int NBARS_W     = 6;
   localparam int DIST_W      = POS_W + 1;
   localparam int EXT_W       = ((POS_W > BW_W) ? POS_W : BW_W) + 3;

   // Configuration port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_WIDTH      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INSTALLED_BARS = 1'd1;
   localparam logic [BW_W-1:0]      BAR_WIDTH_RESET    = 16'd1536;
   localparam logic [NBARS_W-1:0]   INSTALLED_RESET    = 6'd46;

   // Request operations
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_FIRST    = 8'b0000_0010,
      S_CHECK    = 8'b0000_0100,
      S_SEARCH   = 8'b0000_1000,
      S_LOW_READ = 8'b0001_0000,
      S_NB_LO    = 8'b0010_0000,
      S_NB_HI    = 8'b0100_0000,
      S_OUT      = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      RD_FIRST,
      RD_LAST,
      RD_MID_INIT,
      RD_MID_STEP,
      RD_BELOW,
      RD_ABOVE
   } rd_sel_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_ONE,
      RES_MID,
      RES_BELOW,
      RES_ABOVE
   } res_sel_type;

   typedef struct packed {
      logic        load_wr;
      logic        start;
      rd_sel_type  rd_sel;
      logic        keep_first;
      logic        init_search;
      logic        step_search;
      logic        mid_from_first;
      logic        set_res;
      res_sel_type res_sel;
      logic        publish;
   } cmd_type;

   typedef struct packed {
      logic out_range;
      logic at_first;
      logic init_done;
      logic step_done;
      logic has_below;
      logic has_above;
      logic nearer;
   } status_type;

endpackage

`default_nettype wire

[src/nbps_datapath.sv]
`default_nettype none

module nbps_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_enable,
   input  wire logic [nbps_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [nbps_pkg::CSR_DATA_W-1:0]         csr_data,
   input  wire logic [nbps_pkg::ENTRY_W-1:0]            req_entry_index,
   input  wire logic signed [nbps_pkg::POS_W-1:0]       req_entry_position,
   input  wire logic signed [nbps_pkg::POS_W-1:0]       req_query_position,
   input  wire nbps_pkg::cmd_type                       cmd,
   output nbps_pkg::status_type                         status,
   output logic [nbps_pkg::BAR_W-1:0]                   rsp_bar_number
);

   localparam int POS_W   = nbps_pkg::POS_W;
   localparam int IDX_W   = nbps_pkg::IDX_W;
   localparam int SUM_W   = nbps_pkg::SUM_W;
   localparam int BAR_W   = nbps_pkg::BAR_W;
   localparam int DIST_W  = nbps_pkg::DIST_W;
   localparam int EXT_W   = nbps_pkg::EXT_W;

   // Configuration registers
   logic [nbps_pkg::BW_W-1:0]    bar_width_ff;
   logic [nbps_pkg::NBARS_W-1:0] installed_ff;

   // Position memory
   logic signed [POS_W-1:0] pos_mem [nbps_pkg::TABLE_DEPTH];
   logic signed [POS_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_ok;

   // Search state
   logic signed [POS_W-1:0] y_ff;
   logic signed [POS_W-1:0] t1_ff;
   logic [IDX_W-1:0]        n_ff;
   logic [IDX_W-1:0]        n_sat;
   logic signed [SUM_W-1:0] lo_ff;
   logic signed [SUM_W-1:0] hi_ff;
   logic [IDX_W-1:0]        jm_ff;
   logic [DIST_W-1:0]       dmid_ff;
   logic [BAR_W-1:0]        res_ff;
   logic [BAR_W-1:0]        res_in;
   logic [BAR_W-1:0]        bar_ff;

   logic signed [SUM_W-1:0] jm_s;
   logic signed [SUM_W-1:0] lo_in;
   logic signed [SUM_W-1:0] hi_in;
   logic signed [SUM_W-1:0] sum_step;
   logic [SUM_W-1:0]        sum_init;
   logic [IDX_W-1:0]        mid_step;
   logic [IDX_W-1:0]        mid_init;
   logic [IDX_W:0]          jm_up;
   logic                    ge;

   logic signed [EXT_W-1:0] y2;
   logic signed [EXT_W-1:0] bw_x;
   logic signed [EXT_W-1:0] lim_lo;
   logic signed [EXT_W-1:0] lim_hi;
   logic [DIST_W-1:0]       dist_now;
   logic [DIST_W-1:0]       dist_first;

   function automatic logic [DIST_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                   input logic signed [POS_W-1:0] b);
      logic signed [DIST_W-1:0] d;
      d = DIST_W'(a) - DIST_W'(b);
      return d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_width_ff <= nbps_pkg::BAR_WIDTH_RESET;
         installed_ff <= nbps_pkg::INSTALLED_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == nbps_pkg::CSR_BAR_WIDTH) begin
            bar_width_ff <= nbps_pkg::BW_W'(csr_data);
         end
         if (csr_index == nbps_pkg::CSR_INSTALLED_BARS) begin
            installed_ff <= nbps_pkg::NBARS_W'(csr_data);
         end
      end
   end

   assign n_sat = (32'(installed_ff) > 32'(nbps_pkg::TABLE_DEPTH - 1)) ?
                  IDX_W'(nbps_pkg::TABLE_DEPTH - 1) : IDX_W'(installed_ff);

   assign wr_ok = 32'(req_entry_index) < 32'(nbps_pkg::TABLE_DEPTH);

   // Search arithmetic
   assign jm_s     = signed'(SUM_W'(jm_ff));
   assign ge       = y_ff >= rd_data_ff;
   assign lo_in    = ge ? jm_s : lo_ff;
   assign hi_in    = ge ? hi_ff : jm_s;
   assign sum_step = hi_in + lo_in;
   assign mid_step = IDX_W'(sum_step >>> 1);
   assign sum_init = SUM_W'(n_ff) - SUM_W'(1);
   assign mid_init = IDX_W'(sum_init >> 1);
   assign jm_up    = {1'b0, jm_ff} + (IDX_W+1)'(1);

   always_comb begin
      unique case (cmd.rd_sel)
         nbps_pkg::RD_FIRST:    rd_addr = IDX_W'(1);
         nbps_pkg::RD_LAST:     rd_addr = n_ff;
         nbps_pkg::RD_MID_INIT: rd_addr = mid_init;
         nbps_pkg::RD_MID_STEP: rd_addr = mid_step;
         nbps_pkg::RD_BELOW:    rd_addr = jm_ff - IDX_W'(1);
         nbps_pkg::RD_ABOVE:    rd_addr = jm_ff + IDX_W'(1);
         default:               rd_addr = IDX_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && wr_ok) begin
         pos_mem[IDX_W'(req_entry_index)] <= req_entry_position;
      end
      rd_data_ff <= pos_mem[rd_addr];
   end

   // Range limits on doubled positions, so half a bar needs no rounding
   assign y2     = EXT_W'(y_ff) <<< 1;
   assign bw_x   = signed'(EXT_W'(bar_width_ff));
   assign lim_lo = (EXT_W'(t1_ff) <<< 1) - bw_x;
   assign lim_hi = (EXT_W'(rd_data_ff) <<< 1) + bw_x;

   assign dist_now   = abs_diff(y_ff, rd_data_ff);
   assign dist_first = abs_diff(y_ff, t1_ff);

   assign status.out_range = (y2 < lim_lo) || (y2 > lim_hi);
   assign status.at_first  = y_ff <= t1_ff;
   assign status.init_done = n_ff == '0;
   assign status.step_done = (hi_in - lo_in) <= signed'(SUM_W'(1));
   assign status.has_below = jm_ff != '0;
   assign status.has_above = 32'(jm_up) < 32'(nbps_pkg::TABLE_DEPTH);
   assign status.nearer    = dist_now < dmid_ff;

   always_comb begin
      unique case (cmd.res_sel)
         nbps_pkg::RES_ZERO:  res_in = '0;
         nbps_pkg::RES_ONE:   res_in = BAR_W'(1);
         nbps_pkg::RES_MID:   res_in = BAR_W'(jm_ff);
         nbps_pkg::RES_BELOW: res_in = BAR_W'(jm_ff - IDX_W'(1));
         nbps_pkg::RES_ABOVE: res_in = BAR_W'(jm_up);
         default:             res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         y_ff <= req_query_position;
         n_ff <= n_sat;
      end
      if (cmd.keep_first) begin
         t1_ff <= rd_data_ff;
      end
      if (cmd.init_search) begin
         lo_ff <= -signed'(SUM_W'(1));
         hi_ff <= signed'(SUM_W'(n_ff));
         jm_ff <= mid_init;
      end
      if (cmd.step_search) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         dmid_ff <= dist_now;
         // keep the last midpoint once the range has closed
         if (!status.step_done) begin
            jm_ff <= mid_step;
         end
      end
      if (cmd.mid_from_first) begin
         jm_ff   <= IDX_W'(1);
         dmid_ff <= dist_first;
      end
      if (cmd.set_res) begin
         res_ff <= res_in;
      end
      if (cmd.publish) begin
         bar_ff <= res_ff;
      end
   end

   assign rsp_bar_number = bar_ff;

endmodule

`default_nettype wire

[src/nbps_ctrl.sv]
`default_nettype none

module nbps_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_operation,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire nbps_pkg::status_type status,
   output nbps_pkg::cmd_type         cmd
);

   nbps_pkg::state_type state_ff;
   nbps_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.rd_sel    = nbps_pkg::RD_FIRST;
      cmd.res_sel   = nbps_pkg::RES_ZERO;

      unique case (state_ff)
         nbps_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == nbps_pkg::OP_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = nbps_pkg::S_FIRST;
               end
            end
         end
         nbps_pkg::S_FIRST: begin
            cmd.keep_first = 1'b1;
            cmd.rd_sel     = nbps_pkg::RD_LAST;
            state_in       = nbps_pkg::S_CHECK;
         end
         nbps_pkg::S_CHECK: begin
            priority if (status.out_range) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = nbps_pkg::RES_ZERO;
               state_in    = nbps_pkg::S_OUT;
            end else if (status.at_first) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = nbps_pkg::RES_ONE;
               state_in    = nbps_pkg::S_OUT;
            end else if (status.init_done) begin
               // empty range: midpoint stays on the first entry
               cmd.mid_from_first = 1'b1;
               state_in           = nbps_pkg::S_LOW_READ;
            end else begin
               cmd.init_search = 1'b1;
               cmd.rd_sel      = nbps_pkg::RD_MID_INIT;
               state_in        = nbps_pkg::S_SEARCH;
            end
         end
         nbps_pkg::S_SEARCH: begin
            cmd.step_search = 1'b1;
            if (status.step_done) begin
               cmd.rd_sel = nbps_pkg::RD_BELOW;
               state_in   = nbps_pkg::S_NB_LO;
            end else begin
               cmd.rd_sel = nbps_pkg::RD_MID_STEP;
            end
         end
         nbps_pkg::S_LOW_READ: begin
            cmd.rd_sel = nbps_pkg::RD_BELOW;
            state_in   = nbps_pkg::S_NB_LO;
         end
         nbps_pkg::S_NB_LO: begin
            if (status.has_below && status.nearer) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = nbps_pkg::RES_BELOW;
               state_in    = nbps_pkg::S_OUT;
            end else begin
               cmd.rd_sel = nbps_pkg::RD_ABOVE;
               state_in   = nbps_pkg::S_NB_HI;
            end
         end
         nbps_pkg::S_NB_HI: begin
            cmd.set_res = 1'b1;
            cmd.res_sel = (status.has_above && status.nearer) ?
                          nbps_pkg::RES_ABOVE : nbps_pkg::RES_MID;
            state_in    = nbps_pkg::S_OUT;
         end
         nbps_pkg::S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = nbps_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nbps_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nbps_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/nearest_bar_position_search.sv]
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  operation, entry_index, entry_position, query_position
// rsp      out  rsp_valid/rsp_ready  bar_number
// csr      in   csr_write_enable     csr_index, csr_data
//
// A load request is written while the block stays idle. A lookup outside the bars or at or
// below the first entry finishes after the range check; any other lookup runs a binary
// search over the installed entries, then checks the lower neighbor of the midpoint and,
// unless it is nearer, the upper one; each step is paced by one registered read.
// Reset clears control state and the configuration registers only. A result waits in
// the output register; loads pass meanwhile, but a finished lookup holds the input off.
`default_nettype none

module nearest_bar_position_search (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_operation,
   input  wire logic [nbps_pkg::ENTRY_W-1:0]        req_entry_index,
   input  wire logic signed [nbps_pkg::POS_W-1:0]   req_entry_position,
   input  wire logic signed [nbps_pkg::POS_W-1:0]   req_query_position,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [nbps_pkg::BAR_W-1:0]               rsp_bar_number,
   input  wire logic                                csr_write_enable,
   input  wire logic [nbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [nbps_pkg::CSR_DATA_W-1:0]     csr_data
);

   nbps_pkg::cmd_type    cmd;
   nbps_pkg::status_type status;

   nbps_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   nbps_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_entry_index    (req_entry_index),
      .req_entry_position (req_entry_position),
      .req_query_position (req_query_position),
      .cmd                (cmd),
      .status             (status),
      .rsp_bar_number     (rsp_bar_number)
   );

endmodule

`default_nettype wire
